FILE: sv/bounded_packet_fifo_with_range_count_assert.svh
// ----------------------------------------------------------------------------
// bounded_packet_fifo_with_range_count assertion macros
// Shared property wrappers, clocked on clk and held off during arst_n.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_PACKET_FIFO_WITH_RANGE_COUNT_ASSERT_SVH
`define BOUNDED_PACKET_FIFO_WITH_RANGE_COUNT_ASSERT_SVH

// same-cycle implication
`define BPF_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define BPF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: sv/bpf_pkg.sv
// ----------------------------------------------------------------------------
// bpf_pkg
// Request codes, field widths and controller/datapath handshake types.
// ----------------------------------------------------------------------------
package bpf_pkg;

	localparam int SRC_W  = 16;
	localparam int DST_W  = 16;
	localparam int TIME_W = 32;
	localparam int CAP_W  = 7;
	localparam int CNT_W  = 7;
	localparam int WORD_W = SRC_W + DST_W + TIME_W;

	localparam logic [1:0] REQ_ADD = 2'd0;
	localparam logic [1:0] REQ_FWD = 2'd1;
	localparam logic [1:0] REQ_CNT = 2'd2;

	localparam logic [CNT_W-1:0] CNT_MAX = 7'd127;
	localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

	typedef struct packed {
		logic load;     // latch the request beat
		logic scan_rd;  // read one stored entry
		logic commit;   // apply the update and load the result
	} ctrl_cmd_t;

	typedef struct packed {
		logic scan_needed; // incoming request has stored entries to visit
		logic last_rd;     // current read is the final one
		logic out_free;    // result register can take a new beat
	} ctrl_sts_t;

endpackage

FILE: sv/bounded_packet_fifo_with_range_count.sv
// ----------------------------------------------------------------------------
// bounded_packet_fifo_with_range_count
// Packet FIFO with duplicate refusal, eviction at capacity and window count.
// ----------------------------------------------------------------------------
// One request is handled at a time. Add and count walk every stored entry
// through the single-port entry memory, one read per cycle, then drain and
// commit; forward reads only the head entry; on an empty buffer the sweep is
// skipped. The result sits in an output register, so the next request is
// accepted while a result beat still waits, and its commit holds until that
// beat is taken. The user must write capacity_limit on the cfg channel only
// while no request is pending; the block does not enforce it. Zero acts as
// one and values above BUFFER_DEPTH act as BUFFER_DEPTH.
module bounded_packet_fifo_with_range_count #(
	parameter int BUFFER_DEPTH = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [127:0] s_tdata,   // src_id, dst_id, pkt_time, window_start, window_end
	input  logic [1:0]   s_tuser,   // req_type
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [71:0]  m_tdata,   // out_src, out_dst, out_time, match_count, zero pad
	output logic [0:0]   m_tuser,   // ok_flag
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [6:0]   cfg_data   // capacity_limit
);

	logic [bpf_pkg::CAP_W-1:0] capacity_q;
	bpf_pkg::ctrl_cmd_t        cmd;
	bpf_pkg::ctrl_sts_t        sts;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= bpf_pkg::CAP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			capacity_q <= cfg_data;
		end
	end

	bpf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	bpf_dpath #(
		.DEPTH (BUFFER_DEPTH)
	) u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.capacity (capacity_q),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cmd      (cmd),
		.sts      (sts)
	);

endmodule

FILE: sv/bpf_ctrl.sv
// ----------------------------------------------------------------------------
// bpf_ctrl
// Request sequencer: accept, sweep the stored entries and drain (skipped on an empty buffer), commit.
// ----------------------------------------------------------------------------
module bpf_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  bpf_pkg::ctrl_sts_t  sts,
	output bpf_pkg::ctrl_cmd_t  cmd
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;
	localparam logic [1:0] ST_DONE  = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_nxt;

	assign s_tready    = (state_q == ST_IDLE);
	assign cmd.load    = s_tvalid && s_tready;
	assign cmd.scan_rd = (state_q == ST_SCAN);
	assign cmd.commit  = (state_q == ST_DONE) && sts.out_free;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					state_nxt = sts.scan_needed ? ST_SCAN : ST_DONE;
				end
			end
			ST_SCAN: begin
				if (sts.last_rd) begin
					state_nxt = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_nxt = ST_DONE;
			end
			ST_DONE: begin
				if (sts.out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

FILE: sv/bpf_dpath.sv
// ----------------------------------------------------------------------------
// bpf_dpath
// Entry memory, ring pointers, occupancy, match logic and result register.
// ----------------------------------------------------------------------------
`include "bounded_packet_fifo_with_range_count_assert.svh"

module bpf_dpath #(
	parameter int DEPTH = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [127:0]                  s_tdata,
	input  logic [1:0]                    s_tuser,
	input  logic [bpf_pkg::CAP_W-1:0]     capacity,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [71:0]                   m_tdata,
	output logic [0:0]                    m_tuser,
	input  bpf_pkg::ctrl_cmd_t            cmd,
	output bpf_pkg::ctrl_sts_t            sts
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int OCC_W = $clog2(DEPTH + 1);
	localparam int CMP_W = (OCC_W > bpf_pkg::CAP_W) ? OCC_W : bpf_pkg::CAP_W;

	logic [bpf_pkg::WORD_W-1:0] entry_mem_q [DEPTH];

	logic [PTR_W-1:0] head_q, tail_q, scan_ptr_q;
	logic [OCC_W-1:0] occ_q, left_q;

	logic [1:0]                  req_q;
	logic [bpf_pkg::SRC_W-1:0]   src_q;
	logic [bpf_pkg::DST_W-1:0]   dst_q;
	logic [bpf_pkg::TIME_W-1:0]  time_q, ws_q, we_q;

	logic [bpf_pkg::WORD_W-1:0]  rd_data_s1;
	logic                        rd_vld_s1;
	logic                        dup_q;
	logic [bpf_pkg::CNT_W-1:0]   cnt_q;

	logic                        m_valid_q;
	logic [71:0]                 m_data_q;
	logic                        m_user_q;

	logic [bpf_pkg::DST_W-1:0]   rd_dst;
	logic [bpf_pkg::TIME_W-1:0]  rd_time;
	logic                        hit;
	logic                        full;
	logic [bpf_pkg::CAP_W-1:0]   eff_cap;
	logic                        add_ok;
	logic                        fwd_ok;
	logic [71:0]                 res_data;
	logic                        res_ok;

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		next_ptr = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	assign rd_dst  = rd_data_s1[bpf_pkg::TIME_W +: bpf_pkg::DST_W];
	assign rd_time = rd_data_s1[bpf_pkg::TIME_W-1:0];
	assign hit     = (rd_dst == dst_q) && (rd_time >= ws_q) && (rd_time <= we_q);

	// zero capacity acts as one, capacity above the depth is capped by the depth
	assign eff_cap = (capacity == '0) ? bpf_pkg::CAP_W'(1) : capacity;
	assign full    = (CMP_W'(occ_q) >= CMP_W'(eff_cap)) || (occ_q == OCC_W'(DEPTH));

	assign add_ok = !dup_q;
	assign fwd_ok = (occ_q != '0);

	assign sts.scan_needed = (occ_q != '0) &&
		((s_tuser == bpf_pkg::REQ_ADD) || (s_tuser == bpf_pkg::REQ_FWD) ||
		 (s_tuser == bpf_pkg::REQ_CNT));
	assign sts.last_rd  = (left_q == OCC_W'(1));
	assign sts.out_free = !m_valid_q || m_tready;

	always_comb begin
		res_data = '0;
		res_ok   = 1'b0;
		case (req_q)
			bpf_pkg::REQ_ADD: begin
				res_ok = add_ok;
			end
			bpf_pkg::REQ_FWD: begin
				res_ok = fwd_ok;
				if (fwd_ok) begin
					res_data[15:0]  = rd_data_s1[63:48];
					res_data[31:16] = rd_data_s1[47:32];
					res_data[63:32] = rd_data_s1[31:0];
				end
			end
			bpf_pkg::REQ_CNT: begin
				res_data[70:64] = cnt_q;
			end
			default: begin
				res_ok = 1'b0;
			end
		endcase
	end

	// entry memory, one access per cycle
	always_ff @(posedge clk) begin
		if (cmd.commit && (req_q == bpf_pkg::REQ_ADD) && add_ok) begin
			entry_mem_q[tail_q] <= {src_q, dst_q, time_q};
		end
		if (cmd.scan_rd) begin
			rd_data_s1 <= entry_mem_q[scan_ptr_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q  <= s_tuser;
			src_q  <= s_tdata[15:0];
			dst_q  <= s_tdata[31:16];
			time_q <= s_tdata[63:32];
			ws_q   <= s_tdata[95:64];
			we_q   <= s_tdata[127:96];
		end
		if (cmd.commit) begin
			m_data_q <= res_data;
			m_user_q <= res_ok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q     <= '0;
			tail_q     <= '0;
			occ_q      <= '0;
			scan_ptr_q <= '0;
			left_q     <= '0;
			rd_vld_s1  <= 1'b0;
			dup_q      <= 1'b0;
			cnt_q      <= '0;
			m_valid_q  <= 1'b0;
		end else begin
			rd_vld_s1 <= cmd.scan_rd;
			if (cmd.load) begin
				scan_ptr_q <= head_q;
				left_q     <= (s_tuser == bpf_pkg::REQ_FWD) ? OCC_W'(1) : occ_q;
				dup_q      <= 1'b0;
				cnt_q      <= '0;
			end else if (cmd.scan_rd) begin
				scan_ptr_q <= next_ptr(scan_ptr_q);
				left_q     <= left_q - OCC_W'(1);
			end
			if (rd_vld_s1) begin
				if (rd_data_s1 == {src_q, dst_q, time_q}) begin
					dup_q <= 1'b1;
				end
				if (hit && (cnt_q != bpf_pkg::CNT_MAX)) begin
					cnt_q <= cnt_q + bpf_pkg::CNT_W'(1);
				end
			end
			if (cmd.commit) begin
				case (req_q)
					bpf_pkg::REQ_ADD: begin
						if (add_ok) begin
							tail_q <= next_ptr(tail_q);
							// full: oldest entry drops out, occupancy holds
							if (full) begin
								head_q <= next_ptr(head_q);
							end else begin
								occ_q <= occ_q + OCC_W'(1);
							end
						end
					end
					bpf_pkg::REQ_FWD: begin
						if (fwd_ok) begin
							head_q <= next_ptr(head_q);
							occ_q  <= occ_q - OCC_W'(1);
						end
					end
					default: begin
					end
				endcase
			end
			if (cmd.commit) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tuser  = m_user_q;

	`BPF_ASSERT_NOW(a_occ_bound, 1'b1, occ_q <= OCC_W'(DEPTH), "occupancy above depth")
	`BPF_ASSERT_NOW(a_commit_free, cmd.commit, sts.out_free, "commit into busy result register")
	`BPF_ASSERT_NOW(a_scan_left, cmd.scan_rd, left_q != '0, "entry read past occupancy")
	`BPF_ASSERT_NEXT(a_commit_out, cmd.commit, m_tvalid, "commit without result beat")

endmodule
